>>> rtl/xcs_pkg.sv
// Shared types and constants for the XMODEM checksum block sender.
package xcs_pkg;

	localparam int unsigned LENGTH_BITS = 24;
	localparam int unsigned CFG_DATA_BITS = 16;

	// item commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_RX    = 2'd2;
	localparam logic [1:0] CMD_TX    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_HYPER   = 2'd0;
	localparam logic [1:0] CFG_RETRY   = 2'd1;
	localparam logic [1:0] CFG_GARBAGE = 2'd2;

	localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd5;
	localparam logic [15:0] GARBAGE_LIMIT_RST = 16'd1024;

	// line characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_SUB = 8'h1a;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_UC  = 8'h43;
	localparam logic [7:0] CH_LC  = 8'h63;
	localparam logic [7:0] RX_MASK = 8'h7f;

	typedef struct packed {
		logic [1:0]             command;
		logic [LENGTH_BITS-1:0] length;
		logic [7:0]             data_byte;
		logic [7:0]             rx_char;
	} in_word_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       frame_end;
		logic       need_data;
		logic [2:0] phase;
	} out_word_t;

endpackage

>>> rtl/xmodem_checksum_sender.sv
// XMODEM checksum block sender: one word in, one result word out, per cycle unless stalled.
// Accepts one word every cycle unless stalled and returns one result word for each via
// a decode stage register, then the output register. Control counters sit in flops and
// are updated in the decode stage; the block payload lives in a single frame buffer memory
// of BLOCK_BYTES bytes, written by load words and read at decode for transmit slots,
// so the checksum is accumulated in the output stage as each payload byte leaves.
// The frame buffer is not cleared; only bytes loaded for the current block are ever read.
// Written retry and garbage limits take effect at the next start word; hyper mode at once.
module xmodem_checksum_sender #(
	parameter int unsigned BLOCK_BYTES = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  xcs_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output xcs_pkg::out_word_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [xcs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int unsigned LB = xcs_pkg::LENGTH_BITS;
	localparam int unsigned FW = $clog2(BLOCK_BYTES + 1);
	localparam int unsigned IW = $clog2(BLOCK_BYTES + 4);
	localparam int unsigned AW = $clog2(BLOCK_BYTES);
	localparam logic [IW-1:0] IDX_SUM   = IW'(BLOCK_BYTES + 3);
	localparam logic [IW-1:0] IDX_DATA0 = IW'(3);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LOAD  = 3'd1,
		PH_SEND  = 3'd2,
		PH_WAIT  = 3'd3,
		PH_DONE  = 3'd4,
		PH_ABORT = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		TK_NONE,
		TK_CONST,
		TK_SOH,
		TK_DATA,
		TK_PAD,
		TK_SUM
	} tx_kind_t;

	typedef struct packed {
		tx_kind_t   kind;
		logic [7:0] byte_val;
		logic       frame_end;
		logic       need_data;
		logic [2:0] phase;
	} s1_word_t;

	// configuration
	logic        hyper_q;
	logic [3:0]  retry_lim_q;
	logic [15:0] garb_lim_q;

	// transfer state
	phase_t          phase_q, phase_d;
	logic [7:0]      blk_num_q, blk_num_d;
	logic [LB-1:0]   remain_q, remain_d;
	logic [FW-1:0]   fill_q, fill_d;
	logic [IW-1:0]   sidx_q, sidx_d;
	logic [4:0]      retries_q, retries_d;
	logic [15:0]     garbage_q, garbage_d;
	logic            eot_q, eot_d;
	logic            first_q, first_d;

	// pipeline
	logic                 valid_s1;
	s1_word_t             word_s1, word_d;
	logic [7:0]           rd_data_s1;
	logic                 out_valid_q;
	xcs_pkg::out_word_t   out_q;
	logic [7:0]           sum_q;

	logic [7:0]      frame_mem_q [BLOCK_BYTES];
	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [IW-1:0]   data_k;
	logic [7:0]      rx7;
	logic            is_quirk, is_ack, is_neg, adv, accept;
	logic [4:0]      retries_dec;

	function automatic logic fill_short(input logic [FW-1:0] fill, input logic [LB-1:0] remain);
		fill_short = (LB'(fill) < remain) && (fill < FW'(BLOCK_BYTES));
	endfunction

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	assign rx7      = in_data.rx_char & xcs_pkg::RX_MASK;
	assign is_quirk = (rx7 == xcs_pkg::CH_UF) || (rx7 == xcs_pkg::CH_LF) ||
		(rx7 == xcs_pkg::CH_AMP);
	assign is_ack   = (rx7 == xcs_pkg::CH_ACK) || (hyper_q && is_quirk);
	assign is_neg   = (rx7 == xcs_pkg::CH_NAK) || (rx7 == xcs_pkg::CH_UC) ||
		(rx7 == xcs_pkg::CH_LC);
	assign retries_dec = (retries_q != 5'd0) ? retries_q - 5'd1 : 5'd0;
	assign data_k   = sidx_q - IDX_DATA0;
	assign wr_addr  = fill_q[AW-1:0];
	assign rd_addr  = data_k[AW-1:0];

	always_comb begin
		phase_d   = phase_q;
		blk_num_d = blk_num_q;
		remain_d  = remain_q;
		fill_d    = fill_q;
		sidx_d    = sidx_q;
		retries_d = retries_q;
		garbage_d = garbage_q;
		eot_d     = eot_q;
		first_d   = first_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		word_d    = '{kind: TK_NONE, byte_val: 8'd0, frame_end: 1'b0,
			need_data: 1'b0, phase: 3'd0};
		case (in_data.command)
			xcs_pkg::CMD_START: begin
				remain_d  = in_data.length;
				blk_num_d = 8'd1;
				fill_d    = '0;
				sidx_d    = '0;
				retries_d = {1'b0, retry_lim_q} + 5'd1;
				garbage_d = garb_lim_q;
				first_d   = 1'b1;
				if (in_data.length == '0) begin
					eot_d   = 1'b1;
					phase_d = PH_SEND;
				end else begin
					eot_d   = 1'b0;
					phase_d = PH_LOAD;
				end
			end
			xcs_pkg::CMD_LOAD: begin
				if (phase_q == PH_LOAD && fill_short(fill_q, remain_q)) begin
					wr_en  = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			xcs_pkg::CMD_RX: begin
				if (phase_q == PH_WAIT) begin
					if (is_ack) begin
						remain_d = remain_q - LB'(fill_q);
						if (remain_d != '0) begin
							blk_num_d = blk_num_q + 8'd1;
							fill_d    = '0;
							first_d   = 1'b0;
							phase_d   = PH_LOAD;
						end else begin
							eot_d   = 1'b1;
							phase_d = PH_SEND;
						end
					end else if (is_quirk) begin
						// quirk acknowledge without hyper mode: drop
					end else if (is_neg) begin
						retries_d = retries_dec;
						if (retries_dec != 5'd0) begin
							sidx_d  = '0;
							phase_d = PH_SEND;
						end else begin
							phase_d = PH_ABORT;
						end
					end else if (rx7 == xcs_pkg::CH_CAN || rx7 == xcs_pkg::CH_SUB) begin
						phase_d = PH_ABORT;
					end else if (garbage_q == 16'd0) begin
						phase_d = PH_ABORT;
					end else begin
						garbage_d = garbage_q - 16'd1;
					end
				end
			end
			default: begin
				if (phase_q == PH_SEND) begin
					if (eot_q) begin
						word_d.kind      = TK_CONST;
						word_d.byte_val  = xcs_pkg::CH_EOT;
						word_d.frame_end = 1'b1;
						eot_d            = 1'b0;
						phase_d          = PH_DONE;
					end else if (sidx_q == IW'(0)) begin
						word_d.kind = TK_SOH;
						sidx_d      = IW'(1);
					end else if (sidx_q == IW'(1)) begin
						word_d.kind     = TK_CONST;
						word_d.byte_val = blk_num_q;
						sidx_d          = IW'(2);
					end else if (sidx_q == IW'(2)) begin
						word_d.kind     = TK_CONST;
						word_d.byte_val = ~blk_num_q;
						sidx_d          = IDX_DATA0;
					end else if (sidx_q < IDX_SUM) begin
						// fetch the payload byte now, pad past the loaded count
						if (data_k < IW'(fill_q)) begin
							word_d.kind = TK_DATA;
							rd_en       = 1'b1;
						end else begin
							word_d.kind = TK_PAD;
						end
						sidx_d = sidx_q + IW'(1);
					end else begin
						word_d.kind      = TK_SUM;
						word_d.frame_end = 1'b1;
						sidx_d           = '0;
						phase_d          = PH_WAIT;
					end
				end
			end
		endcase
		// block full: first block waits for the receiver's request
		if (phase_d == PH_LOAD && !fill_short(fill_d, remain_d)) begin
			sidx_d  = '0;
			phase_d = first_d ? PH_WAIT : PH_SEND;
		end
		word_d.need_data = (phase_d == PH_LOAD) && fill_short(fill_d, remain_d);
		word_d.phase     = 3'(phase_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyper_q     <= 1'b0;
			retry_lim_q <= xcs_pkg::RETRY_LIMIT_RST;
			garb_lim_q  <= xcs_pkg::GARBAGE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcs_pkg::CFG_HYPER:   hyper_q     <= cfg_data[0];
				xcs_pkg::CFG_RETRY:   retry_lim_q <= cfg_data[3:0];
				xcs_pkg::CFG_GARBAGE: garb_lim_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			blk_num_q <= 8'd1;
			remain_q  <= '0;
			fill_q    <= '0;
			sidx_q    <= '0;
			retries_q <= {1'b0, xcs_pkg::RETRY_LIMIT_RST} + 5'd1;
			garbage_q <= xcs_pkg::GARBAGE_LIMIT_RST;
			eot_q     <= 1'b0;
			first_q   <= 1'b1;
		end else if (accept) begin
			phase_q   <= phase_d;
			blk_num_q <= blk_num_d;
			remain_q  <= remain_d;
			fill_q    <= fill_d;
			sidx_q    <= sidx_d;
			retries_q <= retries_d;
			garbage_q <= garbage_d;
			eot_q     <= eot_d;
			first_q   <= first_d;
		end
	end

	// frame buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && wr_en)
			frame_mem_q[wr_addr] <= in_data.data_byte;
		if (accept && rd_en)
			rd_data_s1 <= frame_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			word_s1 <= word_d;
	end

	// output stage: form the byte and accumulate the checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= 8'd0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				case (word_s1.kind)
					TK_SOH:  sum_q <= 8'd0;
					TK_DATA: sum_q <= sum_q + rd_data_s1;
					TK_PAD:  sum_q <= sum_q + xcs_pkg::CH_SUB;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q.tx_valid  <= (word_s1.kind != TK_NONE);
			out_q.frame_end <= word_s1.frame_end;
			out_q.need_data <= word_s1.need_data;
			out_q.phase     <= word_s1.phase;
			case (word_s1.kind)
				TK_CONST: out_q.tx_byte <= word_s1.byte_val;
				TK_SOH:   out_q.tx_byte <= xcs_pkg::CH_SOH;
				TK_DATA:  out_q.tx_byte <= rd_data_s1;
				TK_PAD:   out_q.tx_byte <= xcs_pkg::CH_SUB;
				TK_SUM:   out_q.tx_byte <= sum_q;
				default:  out_q.tx_byte <= 8'd0;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach decode stage");

	a_sidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		sidx_q <= IDX_SUM)
		else $error("send index beyond checksum slot");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BLOCK_BYTES))
		else $error("block fill beyond buffer");

	a_load_no_eot: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LOAD |-> !eot_q)
		else $error("EOT pending while loading");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(word_s1))
		else $error("decode stage lost a word under stall");

endmodule

>>> bench/xmodem_checksum_sender_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the XMODEM checksum block sender: directed and random words.
module xmodem_checksum_sender_tb;

	localparam int BLOCK_BYTES = 128;
	localparam int AW = $clog2(BLOCK_BYTES);
	localparam int LEN_BITS = xcs_pkg::LENGTH_BITS;
	localparam int MAX_GAP = 13;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_WORDS = 90;
	localparam int CYCLE_LIMIT = 100000;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LOAD  = 3'd1,
		PH_SEND  = 3'd2,
		PH_WAIT  = 3'd3,
		PH_DONE  = 3'd4,
		PH_ABORT = 3'd5
	} phase_t;

	class xfer_scoreboard;
		bit                     hyper;
		logic [3:0]             retry_lim;
		logic [15:0]            garb_lim;
		phase_t                 ph;
		logic [7:0]             blk_num;
		logic [LEN_BITS-1:0]    remaining;
		logic [7:0]             fill;
		logic [7:0]             idx;
		logic [7:0]             sum;
		logic [4:0]             retries;
		logic [16:0]            garbage;
		bit                     eot_pending;
		bit                     first_blk;
		logic [7:0]             frame_bytes [BLOCK_BYTES];
		xcs_pkg::out_word_t     expected_q [$];
		int                     errors, words, results, frames, eots, aborts;

		function new();
			hyper = 1'b0;
			retry_lim = xcs_pkg::RETRY_LIMIT_RST;
			garb_lim = xcs_pkg::GARBAGE_LIMIT_RST;
			ph = PH_IDLE;
			blk_num = 8'd1;
			remaining = '0;
			fill = '0;
			idx = '0;
			sum = '0;
			retries = {1'b0, retry_lim} + 5'd1;
			garbage = {1'b0, garb_lim};
			eot_pending = 1'b0;
			first_blk = 1'b1;
			errors = 0;
			words = 0;
			results = 0;
			frames = 0;
			eots = 0;
			aborts = 0;
		endfunction

		function void set_reg(logic [1:0] index, logic [xcs_pkg::CFG_DATA_BITS-1:0] value);
			case (index)
			xcs_pkg::CFG_HYPER: hyper = value[0];
			xcs_pkg::CFG_RETRY: retry_lim = value[3:0];
			xcs_pkg::CFG_GARBAGE: garb_lim = value[15:0];
			default: ;
			endcase
		endfunction

		function int block_target();
			return (remaining < BLOCK_BYTES) ? int'(remaining) : BLOCK_BYTES;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void begin_xfer(logic [LEN_BITS-1:0] len);
			remaining = len;
			blk_num = 8'd1;
			fill = '0;
			idx = '0;
			sum = '0;
			retries = {1'b0, retry_lim} + 5'd1;
			garbage = {1'b0, garb_lim};
			first_blk = 1'b1;
			if (len == '0) begin
				eot_pending = 1'b1;
				ph = PH_SEND;
			end else begin
				eot_pending = 1'b0;
				ph = PH_LOAD;
			end
		endfunction

		function void judge(logic [7:0] c);
			bit quirk;
			quirk = (c == xcs_pkg::CH_UF) || (c == xcs_pkg::CH_LF) || (c == xcs_pkg::CH_AMP);
			if (c == xcs_pkg::CH_ACK || (hyper && quirk)) begin
				remaining -= LEN_BITS'(fill);
				if (remaining != '0) begin
					blk_num++;
					fill = '0;
					first_blk = 1'b0;
					ph = PH_LOAD;
				end else begin
					eot_pending = 1'b1;
					ph = PH_SEND;
				end
			end else if (!quirk) begin
				// quirk characters without hyper mode fall through untouched
				if (c == xcs_pkg::CH_NAK || c == xcs_pkg::CH_UC || c == xcs_pkg::CH_LC) begin
					if (retries != '0)
						retries--;
					if (retries != '0) begin
						idx = '0;
						ph = PH_SEND;
					end else begin
						ph = PH_ABORT;
						aborts++;
					end
				end else if (c == xcs_pkg::CH_CAN || c == xcs_pkg::CH_SUB) begin
					ph = PH_ABORT;
					aborts++;
				end else if (garbage == '0) begin
					ph = PH_ABORT;
					aborts++;
				end else begin
					garbage--;
				end
			end
		endfunction

		// Advance the model by one accepted word; return whether the word did anything.
		function bit note_word(xcs_pkg::in_word_t w);
			xcs_pkg::out_word_t r;
			bit acted;
			int k;
			r = '0;
			acted = 1'b0;
			words++;
			case (w.command)
			xcs_pkg::CMD_START: begin
				begin_xfer(w.length);
				acted = 1'b1;
			end
			xcs_pkg::CMD_LOAD: begin
				if (ph == PH_LOAD && int'(fill) < block_target()) begin
					frame_bytes[fill[AW-1:0]] = w.data_byte;
					fill++;
					acted = 1'b1;
				end
			end
			xcs_pkg::CMD_RX: begin
				if (ph == PH_WAIT) begin
					judge(w.rx_char & xcs_pkg::RX_MASK);
					acted = 1'b1;
				end
			end
			default: begin
				if (ph == PH_SEND) begin
					acted = 1'b1;
					r.tx_valid = 1'b1;
					if (eot_pending) begin
						r.tx_byte = xcs_pkg::CH_EOT;
						r.frame_end = 1'b1;
						eot_pending = 1'b0;
						ph = PH_DONE;
						eots++;
					end else if (idx == 8'd0) begin
						r.tx_byte = xcs_pkg::CH_SOH;
						sum = '0;
						idx = 8'd1;
					end else if (idx == 8'd1) begin
						r.tx_byte = blk_num;
						idx = 8'd2;
					end else if (idx == 8'd2) begin
						r.tx_byte = ~blk_num;
						idx = 8'd3;
					end else if (int'(idx) < 3 + BLOCK_BYTES) begin
						k = int'(idx) - 3;
						r.tx_byte = (k < int'(fill)) ? frame_bytes[k[AW-1:0]] : xcs_pkg::CH_SUB;
						sum += r.tx_byte;
						idx++;
					end else begin
						r.tx_byte = sum;
						r.frame_end = 1'b1;
						idx = '0;
						ph = PH_WAIT;
						frames++;
					end
				end
			end
			endcase
			// a full block waits for the handshake only the first time
			if (ph == PH_LOAD && int'(fill) >= block_target()) begin
				idx = '0;
				if (first_blk)
					ph = PH_WAIT;
				else
					ph = PH_SEND;
			end
			r.need_data = (ph == PH_LOAD) && (int'(fill) < block_target());
			r.phase = ph;
			expected_q.push_back(r);
			return acted;
		endfunction

		function void report(string field, int want, int got);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_word(xcs_pkg::out_word_t got);
			xcs_pkg::out_word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: expected none, actual %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (got.tx_valid !== want.tx_valid)
				report("tx_valid", int'(want.tx_valid), int'(got.tx_valid));
			if (got.tx_byte !== want.tx_byte)
				report("tx_byte", int'(want.tx_byte), int'(got.tx_byte));
			if (got.frame_end !== want.frame_end)
				report("frame_end", int'(want.frame_end), int'(got.frame_end));
			if (got.need_data !== want.need_data)
				report("need_data", int'(want.need_data), int'(got.need_data));
			if (got.phase !== want.phase)
				report("phase", int'(want.phase), int'(got.phase));
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	xcs_pkg::in_word_t                 in_data = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	xcs_pkg::out_word_t                out_data;
	logic                              cfg_we = 1'b0;
	logic [1:0]                        cfg_index = '0;
	logic [xcs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	xfer_scoreboard sb;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_request = 1'b0;
	bit word_acted;
	int stall_left = 0;
	int cycles = 0;

	xmodem_checksum_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles", $time, cycles);
			$display("xmodem_checksum_sender_tb: FAIL");
			$finish;
		end
	end

	// Result side: check every result word taken, then draw a random stall, or a long hold on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_word(out_data);
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
			end
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					out_stall <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall && !rx_burst) begin
				stall_left = $urandom_range(0, MAX_GAP);
				if (stall_left > 0)
					out_stall <= 1'b1;
			end
		end
	end

	function automatic xcs_pkg::in_word_t random_word();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[$bits(xcs_pkg::in_word_t)-1:0];
	endfunction

	// Put val into the field that the command uses; leave the rest random.
	function automatic xcs_pkg::in_word_t make_word(logic [1:0] cmd,
			logic [LEN_BITS-1:0] val);
		xcs_pkg::in_word_t w;
		w = random_word();
		w.command = cmd;
		case (cmd)
		xcs_pkg::CMD_START: w.length = val;
		xcs_pkg::CMD_LOAD: w.data_byte = val[7:0];
		xcs_pkg::CMD_RX: w.rx_char = val[7:0];
		default: ;
		endcase
		return w;
	endfunction

	function automatic logic [LEN_BITS-1:0] pick_length();
		int r;
		logic [31:0] bits;
		r = $urandom_range(0, 99);
		bits = $urandom();
		if (r < 12)
			return '0;
		else if (r < 70)
			return LEN_BITS'($urandom_range(1, 40));
		else if (r < 88)
			return LEN_BITS'($urandom_range(41, 300));
		else if (r < 92)
			return LEN_BITS'(BLOCK_BYTES);
		return bits[LEN_BITS-1:0];
	endfunction

	function automatic logic [7:0] pick_reply();
		int r;
		logic [7:0] c;
		logic [31:0] bits;
		r = $urandom_range(0, 19);
		bits = $urandom();
		if (r < 9)
			c = xcs_pkg::CH_ACK;
		else if (r < 10)
			c = xcs_pkg::CH_NAK;
		else if (r < 11)
			c = xcs_pkg::CH_UC;
		else if (r < 12)
			c = xcs_pkg::CH_LC;
		else if (r < 13)
			c = xcs_pkg::CH_UF;
		else if (r < 14)
			c = xcs_pkg::CH_LF;
		else if (r < 15)
			c = xcs_pkg::CH_AMP;
		else if (r < 16)
			c = bits[0] ? xcs_pkg::CH_CAN : xcs_pkg::CH_SUB;
		else
			c = bits[15:8];
		// the top bit is masked off by the block
		c[7] = bits[31];
		return c;
	endfunction

	// Choose the next word from the predicted state, now and then one out of place.
	function automatic xcs_pkg::in_word_t pick_word();
		xcs_pkg::in_word_t w;
		w = random_word();
		if ($urandom_range(0, 249) == 0 ||
				((sb.ph == PH_IDLE || sb.ph == PH_DONE || sb.ph == PH_ABORT) &&
				$urandom_range(0, 4) != 0)) begin
			w.command = xcs_pkg::CMD_START;
			w.length = pick_length();
			return w;
		end
		if ($urandom_range(0, 11) != 0) begin
			case (sb.ph)
			PH_LOAD: begin
				w.command = xcs_pkg::CMD_LOAD;
				return w;
			end
			PH_SEND: begin
				w.command = xcs_pkg::CMD_TX;
				return w;
			end
			PH_WAIT: begin
				w.command = xcs_pkg::CMD_RX;
				w.rx_char = pick_reply();
				return w;
			end
			default: ;
			endcase
		end
		// out-of-place word
		case ($urandom_range(0, 2))
		0: w.command = xcs_pkg::CMD_LOAD;
		1: w.command = xcs_pkg::CMD_RX;
		default: w.command = xcs_pkg::CMD_TX;
		endcase
		return w;
	endfunction

	task automatic send(input xcs_pkg::in_word_t w);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		word_acted = sb.note_word(w);
	endtask

	// Drop valid, wait for every expected word, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index,
			input logic [xcs_pkg::CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(index, value);
	endtask

	task automatic apply_setting(input bit hyper, input logic [3:0] retry,
			input logic [15:0] garbage);
		write_reg(xcs_pkg::CFG_HYPER, {15'd0, hyper});
		write_reg(xcs_pkg::CFG_RETRY, {12'd0, retry});
		write_reg(xcs_pkg::CFG_GARBAGE, garbage);
	endtask

	task automatic run_random(input bit long_hold);
		int acted_words;
		acted_words = 0;
		if (long_hold)
			hold_request = 1'b1;
		while (acted_words < PHASE_WORDS) begin
			send(pick_word());
			if (word_acted)
				acted_words++;
		end
		settle();
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset configuration
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_ACK)));
		send(make_word(xcs_pkg::CMD_TX, '0));
		send(make_word(xcs_pkg::CMD_START, '0));
		send(make_word(xcs_pkg::CMD_LOAD, 24'hFF));
		send(make_word(xcs_pkg::CMD_TX, '0));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_NAK)));
		send(make_word(xcs_pkg::CMD_START, 24'hFFFFFF));
		send(make_word(xcs_pkg::CMD_LOAD, 24'h00));
		send(make_word(xcs_pkg::CMD_LOAD, 24'hFF));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_ACK)));
		send(make_word(xcs_pkg::CMD_START, 24'd2));
		send(make_word(xcs_pkg::CMD_LOAD, 24'hA5));
		send(make_word(xcs_pkg::CMD_LOAD, 24'h5A));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_UF)));
		send(make_word(xcs_pkg::CMD_RX, 24'hC1));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_NAK | ~xcs_pkg::RX_MASK)));
		send(make_word(xcs_pkg::CMD_TX, '0));
		send(make_word(xcs_pkg::CMD_TX, '0));
		send(make_word(xcs_pkg::CMD_TX, '0));
		send(make_word(xcs_pkg::CMD_START, 24'd1));
		send(make_word(xcs_pkg::CMD_LOAD, 24'h80));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_CAN)));
		send(make_word(xcs_pkg::CMD_START, 24'd1));
		send(make_word(xcs_pkg::CMD_LOAD, 24'h7F));
		send(make_word(xcs_pkg::CMD_RX, LEN_BITS'(xcs_pkg::CH_SUB)));
		settle();

		apply_setting(1'b1, 4'd1, 16'd0);
		run_random(1'b0);
		apply_setting(1'b0, 4'd15, 16'hFFFF);
		run_random(1'b1);
		apply_setting(1'b1, 4'd3, 16'd2);
		run_random(1'b0);
		apply_setting(1'b0, 4'd8, 16'd5);
		run_random(1'b0);

		$display("run covered %0d words and %0d result words, %0d mismatches",
			sb.words, sb.results, sb.errors);
		$display("%0d checksum frames, %0d EOTs and %0d aborts seen in %0d cycles",
			sb.frames, sb.eots, sb.aborts, cycles);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("xmodem_checksum_sender_tb: PASS");
		else
			$display("xmodem_checksum_sender_tb: FAIL");
		$finish;
	end

endmodule
